// ----- rtl/hpq_pkg.sv -----
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared types, codes and compare helpers for the binary heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package hpq_pkg;

  localparam int unsigned ValueW  = 64;
  localparam int unsigned CountOW = 11;

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic [CountOW-1:0]       count_out_t;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_ISSUE,
    S_UP_CMP,
    S_POP_ROOT,
    S_POP_LAST,
    S_DN_ISSUE,
    S_DN_LEFT,
    S_DN_RIGHT,
    S_DN_CMP,
    S_PEEK_ROOT,
    S_DONE
  } state_t;

  // a sits correctly above b in the selected flavour (ties are ordered)
  function automatic logic in_order(value_t a, value_t b, logic max_flavour);
    logic r;
    if (max_flavour) r = (a >= b);
    else             r = (a <= b);
    return r;
  endfunction

  // a wins strictly over b as the extreme child
  function automatic logic strictly_better(value_t a, value_t b, logic max_flavour);
    logic r;
    if (max_flavour) r = (a > b);
    else             r = (a < b);
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/hpq_if.sv -----
// ----------------------------------------------------------------------------
// hpq_req_if / hpq_rsp_if
// Valid/ready channels carrying heap requests and heap results.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpq_req_if;
  logic               valid;
  logic               ready;
  hpq_pkg::op_t       op;
  hpq_pkg::value_t    push_value;
  modport source (output valid, output op, output push_value, input ready);
  modport sink   (input valid, input op, input push_value, output ready);
endinterface

interface hpq_rsp_if;
  logic                valid;
  logic                ready;
  hpq_pkg::value_t     root_value;
  hpq_pkg::status_t    status;
  hpq_pkg::count_out_t count_after;
  modport source (output valid, output root_value, output status, output count_after,
                  input ready);
  modport sink   (input valid, input root_value, input status, input count_after,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/hpq_mem.sv -----
// ----------------------------------------------------------------------------
// hpq_mem
// Heap store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hpq_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire hpq_pkg::value_t wdata,
  input  wire logic [AW-1:0]   raddr,
  output hpq_pkg::value_t      rdata
);
  import hpq_pkg::*;

  value_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/binary_heap_priority_queue.sv -----
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// Min/max binary heap of signed 64-bit values held in a single memory.
// ----------------------------------------------------------------------------
// One request word at a time. Peek reads the root, and an error or no-op case
// goes straight to the result. Push sifts up, reading the parent and then
// comparing and writing back at each level climbed. Pop first fetches the root
// and the last entry, then sifts down level by level (read left child, read
// right child, compare, write back). The single read port of the heap memory
// sets these steps. A result word waits in an output register, and the next
// request is taken once the sequencer is idle again.
// max_flavour selects a max-heap when set; changing it does not reorder
// stored data.
`default_nettype none

module binary_heap_priority_queue #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   cfg_we,
  input  wire logic   cfg_data,
  hpq_req_if.sink     req,
  hpq_rsp_if.source   rsp
);
  import hpq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = AW + 2;

  state_t state, state_next;

  logic          max_flavour;
  logic [CW-1:0] cnt;
  logic [AW-1:0] pos;
  logic [AW-1:0] pick;
  value_t        carry;
  value_t        pval;
  value_t        root;
  status_t       stat;

  logic    rsp_valid;
  value_t  rsp_root;
  status_t rsp_status;
  count_out_t rsp_count;

  logic          we;
  logic [AW-1:0] waddr;
  value_t        wdata;
  logic [AW-1:0] raddr;
  value_t        rdata;

  logic          accept;
  logic [AW-1:0] parent;
  logic [IW-1:0] left_w, right_w, cnt_w;
  logic          has_left, has_right;
  logic          load_rsp;

  hpq_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign accept    = req.valid && req.ready;
  assign parent    = (pos - AW'(1)) >> 1;
  assign left_w    = {1'b0, pos, 1'b1};
  assign right_w   = left_w + IW'(1);
  assign cnt_w     = IW'(cnt);
  assign has_left  = left_w < cnt_w;
  assign has_right = right_w < cnt_w;
  assign load_rsp  = (state == S_DONE) && (!rsp_valid || rsp.ready);

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.root_value  = rsp_root;
  assign rsp.status      = rsp_status;
  assign rsp.count_after = rsp_count;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req.op)
            OP_PUSH: state_next = (cnt == CW'(DEPTH)) ? S_DONE : S_UP_ISSUE;
            OP_POP:  state_next = (cnt == '0) ? S_DONE : S_POP_ROOT;
            OP_PEEK: state_next = (cnt == '0) ? S_DONE : S_PEEK_ROOT;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_UP_ISSUE:  state_next = (pos == '0) ? S_DONE : S_UP_CMP;
      S_UP_CMP:    state_next = in_order(rdata, carry, max_flavour) ? S_DONE : S_UP_ISSUE;
      S_POP_ROOT:  state_next = (cnt == '0) ? S_DONE : S_POP_LAST;
      S_POP_LAST:  state_next = S_DN_ISSUE;
      S_DN_ISSUE:  state_next = has_left ? S_DN_LEFT : S_DONE;
      S_DN_LEFT:   state_next = has_right ? S_DN_RIGHT : S_DN_CMP;
      S_DN_RIGHT:  state_next = S_DN_CMP;
      S_DN_CMP:    state_next = in_order(carry, pval, max_flavour) ? S_DONE : S_DN_ISSUE;
      S_PEEK_ROOT: state_next = S_DONE;
      S_DONE:      state_next = load_rsp ? S_IDLE : S_DONE;
      default:     state_next = S_IDLE;
    endcase
  end

  // memory port controls
  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = carry;
    raddr = '0;
    unique case (state)
      S_UP_ISSUE: begin
        raddr = parent;
        we    = (pos == '0);
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (!in_order(rdata, carry, max_flavour)) wdata = rdata;
      end
      S_POP_ROOT: raddr = cnt[AW-1:0];
      S_DN_ISSUE: begin
        raddr = left_w[AW-1:0];
        we    = !has_left;
      end
      S_DN_LEFT:  raddr = right_w[AW-1:0];
      S_DN_CMP: begin
        we = 1'b1;
        if (!in_order(carry, pval, max_flavour)) wdata = pval;
      end
      default: raddr = '0;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      max_flavour <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) max_flavour <= cfg_data;
      if (accept && req.op == OP_PUSH && cnt != CW'(DEPTH)) cnt <= cnt + CW'(1);
      if (accept && req.op == OP_POP && cnt != '0) cnt <= cnt - CW'(1);
      if (load_rsp) rsp_valid <= 1'b1;
      else if (rsp.ready) rsp_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        root  <= '0;
        carry <= req.push_value;
        pos   <= cnt[AW-1:0];
        if (req.op == OP_PUSH && cnt == CW'(DEPTH)) stat <= ST_FULL;
        else if ((req.op == OP_POP || req.op == OP_PEEK) && cnt == '0) stat <= ST_EMPTY;
        else stat <= ST_OK;
      end
      S_UP_CMP: begin
        if (!in_order(rdata, carry, max_flavour)) pos <= parent;
      end
      S_POP_ROOT: root <= rdata;
      S_POP_LAST: begin
        carry <= rdata;
        pos   <= '0;
      end
      S_DN_LEFT: begin
        pval <= rdata;
        pick <= left_w[AW-1:0];
      end
      S_DN_RIGHT: begin
        if (!strictly_better(pval, rdata, max_flavour)) begin
          pval <= rdata;
          pick <= pick + AW'(1);
        end
      end
      S_DN_CMP: begin
        if (!in_order(carry, pval, max_flavour)) pos <= pick;
      end
      S_PEEK_ROOT: root <= rdata;
      default: ;
    endcase
    if (load_rsp) begin
      rsp_root   <= root;
      rsp_status <= stat;
      rsp_count  <= CountOW'(cnt);
    end
  end

endmodule

`default_nettype wire
